// ===== sv/assert_macros.svh =====
// Concurrent assertion macros shared by the RTL of the literal scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk_i edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_CLK(name, !(cond), msg)

`endif

// ===== sv/asls_pkg.sv =====
// Package of codes, types and helpers for the adjacent string literal scanner.
package asls_pkg;

  localparam int unsigned OFFSET_WIDTH_DEFAULT = 16;
  localparam int unsigned OUT_WIDTH = 16;
  localparam logic [31:0] OUT_MAX = 32'd65535;
  localparam logic [7:0]  COUNT_MAX = 8'd255;
  localparam logic [1:0]  QUOTE_RUN_TRIPLE = 2'd3;

  // Characters that steer the scan
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_LEAD    = 4'd1;
  localparam logic [3:0] M_DQ_OPEN = 4'd2;
  localparam logic [3:0] M_DQ_TWO  = 4'd3;
  localparam logic [3:0] M_DQ_BODY = 4'd4;
  localparam logic [3:0] M_DQ_ESC  = 4'd5;
  localparam logic [3:0] M_TRIPLE  = 4'd6;
  localparam logic [3:0] M_SQ_BODY = 4'd7;
  localparam logic [3:0] M_SQ_ESC  = 4'd8;
  localparam logic [3:0] M_GAP     = 4'd9;

  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] quote_run;
    logic [7:0] count;
  } asls_ctl_t;

  typedef struct packed {
    logic                 matched;
    logic [OUT_WIDTH-1:0] token_begin;
    logic [OUT_WIDTH-1:0] token_finish;
    logic [7:0]           literal_count;
  } asls_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

// ===== sv/asls_if.sv =====
// Valid/ready channel interfaces for scanner input items and result items.
interface asls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       scan_start;
  logic       token_wanted;

  modport source (output valid, character, scan_start, token_wanted, input ready);
  modport sink (input valid, character, scan_start, token_wanted, output ready);
endinterface

interface asls_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [15:0] token_begin;
  logic [15:0] token_finish;
  logic [7:0]  literal_count;

  modport source (output valid, matched, token_begin, token_finish, literal_count,
                  input ready);
  modport sink (input valid, matched, token_begin, token_finish, literal_count,
                output ready);
endinterface

// ===== sv/asls_step.sv =====
// Next-state and result logic for one character of the scan.
module asls_step #(
  parameter int unsigned OFFSET_WIDTH = asls_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic [7:0]              char_i,
  input  logic                    start_i,
  input  logic                    want_i,
  input  asls_pkg::asls_ctl_t     ctl_i,
  input  logic [OFFSET_WIDTH-1:0] off_i,
  input  logic [OFFSET_WIDTH-1:0] beg_i,
  input  logic [OFFSET_WIDTH-1:0] last_i,
  output asls_pkg::asls_ctl_t     ctl_o,
  output logic [OFFSET_WIDTH-1:0] off_o,
  output logic [OFFSET_WIDTH-1:0] beg_o,
  output logic [OFFSET_WIDTH-1:0] last_o,
  output logic                    emit_o,
  output asls_pkg::asls_res_t     res_o
);
  import asls_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

  logic [3:0]              mode_cur;
  logic [3:0]              mode_nx;
  logic [1:0]              qr;
  logic [7:0]              cnt;
  logic [OFFSET_WIDTH-1:0] off;
  logic [OFFSET_WIDTH-1:0] off_inc;
  logic [OFFSET_WIDTH-1:0] beg;
  logic [OFFSET_WIDTH-1:0] last;
  logic                    emit;
  logic                    ok;
  logic                    gap_now;
  logic                    is_dq;
  logic [31:0]             beg_w;
  logic [31:0]             last_w;

  function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] v);
    return (v == OFF_MAX) ? v : v + OFFSET_WIDTH'(1);
  endfunction

  always_comb begin
    mode_cur = ctl_i.mode;
    qr       = ctl_i.quote_run;
    cnt      = ctl_i.count;
    off      = off_i;
    beg      = beg_i;
    last     = last_i;
    emit     = 1'b0;
    ok       = 1'b0;
    gap_now  = 1'b0;

    // A new attempt clears the scan state; an unwanted token fails at once
    if (start_i) begin
      off  = '0;
      beg  = '0;
      last = '0;
      qr   = '0;
      cnt  = '0;
      if (want_i) begin
        mode_cur = M_LEAD;
      end else begin
        mode_cur = M_IDLE;
        emit     = 1'b1;
      end
    end

    off_inc = sat_inc(off);
    is_dq   = (mode_cur == M_DQ_OPEN) || (mode_cur == M_DQ_BODY);
    mode_nx = mode_cur;

    if (!emit) begin
      unique case (mode_cur) inside
        M_IDLE: begin
          mode_nx = M_IDLE;
        end
        M_LEAD: begin
          if (is_blank(char_i)) begin
            mode_nx = M_LEAD;
          end else if (char_i == CH_DQ) begin
            beg     = off;
            mode_nx = M_DQ_OPEN;
          end else if (char_i == CH_SQ) begin
            beg     = off;
            mode_nx = M_SQ_BODY;
          end else begin
            emit    = 1'b1;
            mode_nx = M_IDLE;
          end
        end
        M_DQ_OPEN, M_DQ_BODY, M_SQ_BODY: begin
          if ((mode_cur == M_DQ_OPEN) && (char_i == CH_DQ)) begin
            mode_nx = M_DQ_TWO;
          end else if (char_i == CH_NUL) begin
            emit    = 1'b1;
            ok      = (cnt != 8'd0);
            mode_nx = M_IDLE;
          end else if (char_i == CH_BSL) begin
            mode_nx = is_dq ? M_DQ_ESC : M_SQ_ESC;
          end else if (char_i == (is_dq ? CH_DQ : CH_SQ)) begin
            last    = off_inc;
            cnt     = (cnt < COUNT_MAX) ? cnt + 8'd1 : cnt;
            mode_nx = M_GAP;
          end else begin
            mode_nx = is_dq ? M_DQ_BODY : M_SQ_BODY;
          end
        end
        M_DQ_TWO: begin
          if (char_i == CH_DQ) begin
            qr      = '0;
            mode_nx = M_TRIPLE;
          end else begin
            // Empty literal closes here; this char is then looked at as a gap char
            last    = off;
            cnt     = (cnt < COUNT_MAX) ? cnt + 8'd1 : cnt;
            gap_now = 1'b1;
          end
        end
        M_DQ_ESC, M_SQ_ESC: begin
          if (char_i == CH_NUL) begin
            emit    = 1'b1;
            ok      = (cnt != 8'd0);
            mode_nx = M_IDLE;
          end else begin
            mode_nx = (mode_cur == M_DQ_ESC) ? M_DQ_BODY : M_SQ_BODY;
          end
        end
        M_TRIPLE: begin
          if (char_i == CH_NUL) begin
            emit    = 1'b1;
            ok      = (cnt != 8'd0);
            mode_nx = M_IDLE;
          end else if (char_i == CH_DQ) begin
            qr = qr + 2'd1;
            if (qr == QUOTE_RUN_TRIPLE) begin
              last    = off_inc;
              cnt     = (cnt < COUNT_MAX) ? cnt + 8'd1 : cnt;
              mode_nx = M_GAP;
            end
          end else begin
            qr = '0;
          end
        end
        M_GAP: begin
          gap_now = 1'b1;
        end
        default: begin
          mode_nx = M_IDLE;
        end
      endcase
    end

    if (gap_now) begin
      if (is_blank(char_i)) begin
        mode_nx = M_GAP;
      end else if (char_i == CH_DQ) begin
        mode_nx = M_DQ_OPEN;
      end else if (char_i == CH_SQ) begin
        mode_nx = M_SQ_BODY;
      end else begin
        emit    = 1'b1;
        ok      = 1'b1;
        mode_nx = M_IDLE;
      end
    end

    // Advance the offset while the attempt stays open
    off_o = (mode_nx != M_IDLE) ? sat_inc(off) : off;

    beg_w  = 32'(beg);
    last_w = 32'(last);
    res_o.matched       = ok;
    res_o.token_begin   = !ok ? '0 : ((beg_w > OUT_MAX) ? '1 : beg_w[OUT_WIDTH-1:0]);
    res_o.token_finish  = !ok ? '0 : ((last_w > OUT_MAX) ? '1 : last_w[OUT_WIDTH-1:0]);
    res_o.literal_count = ok ? cnt : 8'd0;

    ctl_o.mode      = mode_nx;
    ctl_o.quote_run = qr;
    ctl_o.count     = cnt;
    beg_o           = beg;
    last_o          = last;
    emit_o          = emit;
  end

endmodule

// ===== sv/adjacent_string_literal_scanner.sv =====
// A result is stepped from the input register and loaded into the result register.
// One character per cycle unless results stall; scan state loops through one step.
// Stalls on the result side hold the input register, and ready then drops.
// Reset clears the input and result valid flags and returns the scan to idle,
// with all offsets and the literal count at zero.
module adjacent_string_literal_scanner #(
  parameter int unsigned OFFSET_WIDTH = asls_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  asls_in_if.sink    item_in_i,
  asls_out_if.source result_out_o
);
  import asls_pkg::*;
  `include "assert_macros.svh"

  // Input register: one character item waiting for its step
  logic       in_vq;
  logic [7:0] in_char_q;
  logic       in_start_q;
  logic       in_want_q;

  // Scan state
  asls_ctl_t               ctl_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic [OFFSET_WIDTH-1:0] beg_q;
  logic [OFFSET_WIDTH-1:0] last_q;

  // Step outputs
  asls_ctl_t               ctl_d;
  logic [OFFSET_WIDTH-1:0] off_d;
  logic [OFFSET_WIDTH-1:0] beg_d;
  logic [OFFSET_WIDTH-1:0] last_d;
  logic                    step_emit;
  asls_res_t               step_res;
  logic                    step_fail;

  // Result register
  logic      out_vq;
  asls_res_t res_q;

  logic adv;
  logic in_take;

  // Step the held item when the result slot is free or drains this cycle
  assign adv     = in_vq && (!out_vq || result_out_o.ready);
  assign in_take = item_in_i.valid && item_in_i.ready;
  assign item_in_i.ready = !in_vq || adv;

  asls_step #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_step (
    .char_i  (in_char_q),
    .start_i (in_start_q),
    .want_i  (in_want_q),
    .ctl_i   (ctl_q),
    .off_i   (off_q),
    .beg_i   (beg_q),
    .last_i  (last_q),
    .ctl_o   (ctl_d),
    .off_o   (off_d),
    .beg_o   (beg_d),
    .last_o  (last_d),
    .emit_o  (step_emit),
    .res_o   (step_res)
  );

  assign step_fail = step_emit && !step_res.matched;

  // Hold the input item until it steps; take a new one in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (item_in_i.ready) begin
      in_vq <= item_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q  <= item_in_i.character;
      in_start_q <= item_in_i.scan_start;
      in_want_q  <= item_in_i.token_wanted;
    end
  end

  // Advance the scan state by one character per stepped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '{mode: M_IDLE, quote_run: 2'd0, count: 8'd0};
      off_q  <= '0;
      beg_q  <= '0;
      last_q <= '0;
    end else if (adv) begin
      ctl_q  <= ctl_d;
      off_q  <= off_d;
      beg_q  <= beg_d;
      last_q <= last_d;
    end
  end

  // Result slot: drop on handshake, load when a step decides an attempt
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv && step_emit) begin
      out_vq <= 1'b1;
    end else if (result_out_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && step_emit) begin
      res_q <= step_res;
    end
  end

  assign result_out_o.valid         = out_vq;
  assign result_out_o.matched       = res_q.matched;
  assign result_out_o.token_begin   = res_q.token_begin;
  assign result_out_o.token_finish  = res_q.token_finish;
  assign result_out_o.literal_count = res_q.literal_count;

  // A failed attempt reports all-zero fields
  `ASSERT_CLK(a_fail_zero, (out_vq && !res_q.matched) |-> (res_q == '0), "failed result not zero")
  // A match holds at least one literal
  `ASSERT_NEVER(a_match_count, out_vq && res_q.matched && (res_q.literal_count == 8'd0), "no literals")
  // A decided attempt leaves the scan idle
  `ASSERT_CLK(a_emit_idle, (adv && step_emit) |=> (ctl_q.mode == M_IDLE), "scan not idle")
  // An unwanted token decides on its start character
  `ASSERT_CLK(a_unwanted, (adv && in_start_q && !in_want_q) |-> step_fail, "unwanted not failed")

endmodule
